>>> src/lrf_pkg.sv
// ----------------------------------------------------------------------------
// lrf_pkg: shared types, codes and functions of the log record framer
// Command, status and register codes, the job record passed from the front
// end to the back end, and the CRC-32 and byte selection helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package lrf_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [1:0] CMD_OPEN   = 2'd0;
  localparam logic [1:0] CMD_DATA   = 2'd1;
  localparam logic [1:0] CMD_NOTICE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_RECORD = 2'd1;
  localparam logic [1:0] ST_BUSY      = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_PUT_TYPE    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELETE_TYPE = 1'd1;

  localparam logic [7:0] PUT_TYPE_RESET    = 8'd1;
  localparam logic [7:0] DELETE_TYPE_RESET = 8'd2;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [4:0] HDR_BYTES      = 5'd13;
  localparam logic [4:0] HDR_KEY_BYTES  = 5'd15;
  localparam logic [4:0] HDR_FULL_BYTES = 5'd17;
  localparam logic [4:0] DATA_BYTES     = 5'd1;
  localparam logic [4:0] DATA_VLEN_BYTES = 5'd3;

  typedef enum logic [1:0] {
    JOB_STATUS,
    JOB_OPEN,
    JOB_DATA
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [4:0]  nbytes;
    logic        done;
    logic [1:0]  status;
    logic [63:0] rec_lsn;
    logic [63:0] flushed;
    logic [31:0] txn;
    logic [7:0]  typ;
    logic [15:0] klen;
    logic [15:0] vlen;
    logic [7:0]  data;
  } job_t;

  function automatic logic [31:0] crc_fold(input logic [31:0] crc_in,
                                           input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] byte_sel(input job_t job, input logic [4:0] k);
    logic [135:0] v;
    if (job.kind == JOB_OPEN) begin
      v = {job.vlen, job.klen, job.typ, job.txn, job.rec_lsn};
    end else begin
      v = {112'd0, job.vlen, job.data};
    end
    return v[{k, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

>>> src/lrf_in_if.sv
// ----------------------------------------------------------------------------
// lrf_in_if: command channel of the log record framer
// Valid/ready channel carrying one command word and its operands.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] txn_id;
  logic [7:0]  rec_type;
  logic [15:0] key_len;
  logic [15:0] value_len;
  logic [7:0]  data_byte;
  logic [63:0] written_lsn;

  modport source (output valid, cmd, txn_id, rec_type, key_len, value_len,
                  data_byte, written_lsn, input ready);
  modport sink (input valid, cmd, txn_id, rec_type, key_len, value_len,
                data_byte, written_lsn, output ready);
endinterface

`default_nettype wire

>>> src/lrf_out_if.sv
// ----------------------------------------------------------------------------
// lrf_out_if: result channel of the log record framer
// Valid/ready channel carrying one record byte or status word.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [31:0] crc;
  logic [63:0] record_lsn;
  logic [63:0] flushed_lsn;
  logic [1:0]  status;

  modport source (output valid, out_byte, byte_valid, last, crc, record_lsn,
                  flushed_lsn, status, input ready);
  modport sink (input valid, out_byte, byte_valid, last, crc, record_lsn,
                flushed_lsn, status, output ready);
endinterface

`default_nettype wire

>>> src/lrf_front.sv
// ----------------------------------------------------------------------------
// lrf_front: command decoder and record state
// Accepts command words, tracks the open record and sequence numbers, and
// pushes one job per command, except the unused code, into the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lrf_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  lrf_in_if.sink                               in_ch,
  input  wire logic                            cfg_we,
  input  wire logic [lrf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lrf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            q_full,
  output lrf_pkg::job_t                        job,
  output logic                                 push
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_KEY,
    PH_VALUE
  } phase_t;

  phase_t      phase, phase_next;
  logic [63:0] next_seq, next_seq_next;
  logic [63:0] flushed_seq, flushed_seq_next;
  logic [63:0] current_seq, current_seq_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] pending_value_len, pending_value_len_next;
  logic        is_put, is_put_next;
  logic [7:0]  put_code;
  logic [7:0]  delete_code;
  logic        accept;
  logic        is_put_type;
  logic        is_del_type;
  logic [15:0] bytes_dec;

  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && in_ch.ready;
  assign is_put_type = (in_ch.rec_type == put_code);
  assign is_del_type = (in_ch.rec_type == delete_code);
  assign bytes_dec = bytes_left - 16'd1;

  always_comb begin
    phase_next = phase;
    next_seq_next = next_seq;
    flushed_seq_next = flushed_seq;
    current_seq_next = current_seq;
    bytes_left_next = bytes_left;
    pending_value_len_next = pending_value_len;
    is_put_next = is_put;
    push = 1'b0;
    job.kind = lrf_pkg::JOB_STATUS;
    job.nbytes = lrf_pkg::DATA_BYTES;
    job.done = 1'b0;
    job.status = lrf_pkg::ST_OK;
    job.rec_lsn = current_seq;
    job.flushed = flushed_seq;
    job.txn = in_ch.txn_id;
    job.typ = in_ch.rec_type;
    job.klen = in_ch.key_len;
    job.vlen = in_ch.value_len;
    job.data = in_ch.data_byte;
    if (accept) begin
      case (in_ch.cmd)
        lrf_pkg::CMD_OPEN: begin
          push = 1'b1;
          if (phase != PH_IDLE) begin
            job.status = lrf_pkg::ST_BUSY;
          end else begin
            current_seq_next = next_seq;
            next_seq_next = next_seq + 64'd1;
            job.kind = lrf_pkg::JOB_OPEN;
            job.rec_lsn = next_seq;
            is_put_next = is_put_type;
            if (is_put_type || is_del_type) begin
              job.nbytes = lrf_pkg::HDR_KEY_BYTES;
              if (in_ch.key_len != 16'd0) begin
                phase_next = PH_KEY;
                bytes_left_next = in_ch.key_len;
                pending_value_len_next = in_ch.value_len;
              end else if (is_put_type) begin
                job.nbytes = lrf_pkg::HDR_FULL_BYTES;
                if (in_ch.value_len != 16'd0) begin
                  phase_next = PH_VALUE;
                  bytes_left_next = in_ch.value_len;
                end else begin
                  job.done = 1'b1;
                end
              end else begin
                job.done = 1'b1;
              end
            end else begin
              job.nbytes = lrf_pkg::HDR_BYTES;
              job.done = 1'b1;
            end
          end
        end
        lrf_pkg::CMD_DATA: begin
          push = 1'b1;
          if (phase == PH_IDLE) begin
            job.status = lrf_pkg::ST_NO_RECORD;
          end else begin
            job.kind = lrf_pkg::JOB_DATA;
            job.vlen = pending_value_len;
            bytes_left_next = bytes_dec;
            if (bytes_dec == 16'd0) begin
              if (phase == PH_KEY && is_put) begin
                job.nbytes = lrf_pkg::DATA_VLEN_BYTES;
                if (pending_value_len != 16'd0) begin
                  phase_next = PH_VALUE;
                  bytes_left_next = pending_value_len;
                end else begin
                  job.done = 1'b1;
                  phase_next = PH_IDLE;
                end
              end else begin
                job.done = 1'b1;
                phase_next = PH_IDLE;
              end
            end
          end
        end
        lrf_pkg::CMD_NOTICE: begin
          push = 1'b1;
          if (in_ch.written_lsn > flushed_seq) begin
            flushed_seq_next = in_ch.written_lsn;
          end
          job.flushed = flushed_seq_next;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      next_seq <= 64'd1;
      flushed_seq <= 64'd0;
      current_seq <= 64'd0;
      bytes_left <= 16'd0;
      pending_value_len <= 16'd0;
      is_put <= 1'b0;
      put_code <= lrf_pkg::PUT_TYPE_RESET;
      delete_code <= lrf_pkg::DELETE_TYPE_RESET;
    end else begin
      phase <= phase_next;
      next_seq <= next_seq_next;
      flushed_seq <= flushed_seq_next;
      current_seq <= current_seq_next;
      bytes_left <= bytes_left_next;
      pending_value_len <= pending_value_len_next;
      is_put <= is_put_next;
      if (cfg_we && cfg_index == lrf_pkg::REG_PUT_TYPE) begin
        put_code <= cfg_data;
      end
      if (cfg_we && cfg_index == lrf_pkg::REG_DELETE_TYPE) begin
        delete_code <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/lrf_queue.sv
// ----------------------------------------------------------------------------
// lrf_queue: job queue between front end and back end
// Small first-in first-out store of decoded jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module lrf_queue #(
  parameter int unsigned DEPTH = lrf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire lrf_pkg::job_t push_job,
  input  wire logic          pop,
  output lrf_pkg::job_t      head,
  output logic               empty,
  output logic               full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  lrf_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign empty = (count == '0);
  assign full = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/lrf_back.sv
// ----------------------------------------------------------------------------
// lrf_back: byte sequencer and CRC engine
// Steps through each queued job one result word per cycle while the result
// channel is ready, folds record bytes into the CRC and drives it registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lrf_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire lrf_pkg::job_t head,
  input  wire logic          empty,
  output logic               pop,
  lrf_out_if.source          out_ch
);

  logic [4:0]  k;
  logic [31:0] crc_acc;
  logic        load;
  logic        fire;
  logic        final_word;
  logic        is_status;
  logic        is_last;
  logic [7:0]  cur_byte;
  logic [31:0] crc_start;
  logic [31:0] crc_new;

  assign load = !out_ch.valid || out_ch.ready;
  assign fire = load && !empty;
  assign is_status = (head.kind == lrf_pkg::JOB_STATUS);
  assign final_word = is_status || (k == head.nbytes - 5'd1);
  assign is_last = !is_status && head.done && final_word;
  assign pop = fire && final_word;
  assign cur_byte = lrf_pkg::byte_sel(head, k);
  assign crc_start = (head.kind == lrf_pkg::JOB_OPEN && k == 5'd0) ?
                     lrf_pkg::CRC_INIT : crc_acc;
  assign crc_new = lrf_pkg::crc_fold(crc_start, cur_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      k <= 5'd0;
      crc_acc <= lrf_pkg::CRC_INIT;
    end else begin
      if (load) begin
        out_ch.valid <= !empty;
      end
      if (fire) begin
        k <= final_word ? 5'd0 : k + 5'd1;
        if (!is_status) begin
          crc_acc <= crc_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ch.out_byte <= is_status ? 8'd0 : cur_byte;
      out_ch.byte_valid <= !is_status;
      out_ch.last <= is_last;
      out_ch.crc <= is_last ? ~crc_new : 32'd0;
      out_ch.record_lsn <= head.rec_lsn;
      out_ch.flushed_lsn <= head.flushed;
      out_ch.status <= is_status ? head.status : lrf_pkg::ST_OK;
    end
  end

endmodule

`default_nettype wire

>>> src/log_record_framer_crc32.sv
// ----------------------------------------------------------------------------
// log_record_framer_crc32: write-ahead-log record framer with CRC-32
// Top level joining the command decoder, the job queue and the byte sequencer.
// ----------------------------------------------------------------------------
// The block takes one command word per cycle while its job queue has room.
// Every command except the unused code gives result words, one per cycle from
// the byte sequencer while the result channel is ready: an open gives 13, 15
// or 17 header bytes, a payload byte gives one word, or three when it ends the
// key of a put record, and a refused open, a stray payload byte or a written
// notice gives one status word. Sustained throughput is therefore one result
// word per cycle, set by the sequencer, and the queue of QUEUE_DEPTH jobs lets
// payload commands keep arriving while a header is still being sent. The CRC
// of a record appears on its last byte.
`default_nettype none

module log_record_framer_crc32 #(
  parameter int unsigned QUEUE_DEPTH = lrf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  lrf_in_if.sink                               in_ch,
  lrf_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [lrf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lrf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lrf_pkg::job_t push_job;
  lrf_pkg::job_t head;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;

  lrf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .job       (push_job),
    .push      (push)
  );

  lrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  lrf_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("result channel valid after reset");

  a_status_no_byte: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != lrf_pkg::ST_OK) |-> !out_ch.byte_valid)
    else $error("status word carries a record byte");

  a_crc_only_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.last) |-> (out_ch.crc == 32'd0))
    else $error("crc set on a word that does not close a record");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("job pushed into a full queue");

endmodule

`default_nettype wire

>>> tb/log_record_framer_crc32_tb.sv
// ----------------------------------------------------------------------------
// log_record_framer_crc32_tb: self-checking testbench of the log record framer
// A table of directed commands covers reset values, header extremes, each
// record kind and the refused and stray cases. Random records with noise
// follow under several type code settings, ending with a maximum written
// notice. A model of the framer predicts every result word, including the
// CRC-32 on the last byte. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module log_record_framer_crc32_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 8;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int QUIET_CYCLES = 32;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_KEY,
    PH_VALUE
  } frame_phase_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] txn;
    logic [7:0]  typ;
    logic [15:0] klen;
    logic [15:0] vlen;
    logic [7:0]  data;
    logic [63:0] lsn;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [31:0] crc;
    logic [63:0] record_lsn;
    logic [63:0] flushed_lsn;
    logic [1:0]  status;
  } rec_word_t;

  typedef struct packed {
    cmd_word_t   w;
    logic        typed;
    logic [1:0]  status;
    logic [63:0] record_lsn;
    logic [63:0] flushed_lsn;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [lrf_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lrf_pkg::CFG_DATA_W-1:0] cfg_data;

  lrf_in_if in_ch ();
  lrf_out_if out_ch ();

  log_record_framer_crc32 dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  logic [7:0]   put_code;
  logic [7:0]   del_code;
  logic [63:0]  nxt_lsn;
  logic [63:0]  flush_lsn;
  logic [63:0]  cur_lsn;
  logic [31:0]  crc_run;
  frame_phase_t ph;
  logic [15:0]  left_cnt;
  logic [15:0]  vlen_hold;
  logic         put_rec;

  rec_word_t pending_words[$];
  rec_word_t step_words[$];
  dir_row_t  dir_rows[$];
  int        err_count;
  logic      tx_idle;
  logic      rx_idle;

  task automatic report(input string what, input logic [63:0] got_v,
                        input logic [63:0] want_v);
    $display("%0t ERROR %s: got %h expected %h", $time, what, got_v, want_v);
    err_count++;
  endtask

  task automatic add_row(input dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endtask

  task automatic add_pending(input rec_word_t r);
    pending_words.insert(pending_words.size(), r);
  endtask

  task automatic add_step(input rec_word_t r);
    step_words.insert(step_words.size(), r);
  endtask

  function automatic logic [31:0] crc_step_byte(input logic [31:0] c,
                                                input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (lrf_pkg::CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

  task automatic push_status(input logic [1:0] st);
    add_step(rec_word_t'{8'd0, 1'b0, 1'b0, 32'd0, cur_lsn, flush_lsn, st});
  endtask

  task automatic frame_command(input cmd_word_t w);
    logic [7:0] body[$];
    logic closes;
    logic end_k;
    int k;
    step_words = {};
    closes = 1'b0;
    case (w.cmd)
      lrf_pkg::CMD_OPEN: begin
        if (ph != PH_IDLE) begin
          push_status(lrf_pkg::ST_BUSY);
          return;
        end
        cur_lsn = nxt_lsn;
        nxt_lsn = nxt_lsn + 64'd1;
        crc_run = lrf_pkg::CRC_INIT;
        for (k = 0; k < 8; k++) body.insert(body.size(), cur_lsn[8*k +: 8]);
        for (k = 0; k < 4; k++) body.insert(body.size(), w.txn[8*k +: 8]);
        body.insert(body.size(), w.typ);
        if (w.typ == put_code || w.typ == del_code) begin
          put_rec = (w.typ == put_code);
          body.insert(body.size(), w.klen[7:0]);
          body.insert(body.size(), w.klen[15:8]);
          if (w.klen != 16'd0) begin
            ph = PH_KEY;
            left_cnt = w.klen;
            vlen_hold = w.vlen;
          end else if (put_rec) begin
            body.insert(body.size(), w.vlen[7:0]);
            body.insert(body.size(), w.vlen[15:8]);
            if (w.vlen != 16'd0) begin
              ph = PH_VALUE;
              left_cnt = w.vlen;
            end else begin
              closes = 1'b1;
            end
          end else begin
            closes = 1'b1;
          end
        end else begin
          put_rec = 1'b0;
          closes = 1'b1;
        end
      end
      lrf_pkg::CMD_DATA: begin
        if (ph == PH_IDLE) begin
          push_status(lrf_pkg::ST_NO_RECORD);
          return;
        end
        body.insert(body.size(), w.data);
        left_cnt = left_cnt - 16'd1;
        if (left_cnt == 16'd0) begin
          if (ph == PH_KEY && put_rec) begin
            body.insert(body.size(), vlen_hold[7:0]);
            body.insert(body.size(), vlen_hold[15:8]);
            if (vlen_hold != 16'd0) begin
              ph = PH_VALUE;
              left_cnt = vlen_hold;
            end else begin
              closes = 1'b1;
            end
          end else begin
            closes = 1'b1;
          end
        end
      end
      lrf_pkg::CMD_NOTICE: begin
        if (w.lsn > flush_lsn) flush_lsn = w.lsn;
        push_status(lrf_pkg::ST_OK);
        return;
      end
      default: return;
    endcase
    for (k = 0; k < body.size(); k++) begin
      crc_run = crc_step_byte(crc_run, body[k]);
      end_k = closes && (k == body.size() - 1);
      add_step(rec_word_t'{body[k], 1'b1, end_k, end_k ? ~crc_run : 32'd0,
                           cur_lsn, flush_lsn, lrf_pkg::ST_OK});
    end
    if (closes) ph = PH_IDLE;
  endtask

  function automatic cmd_word_t open_w(input logic [31:0] txn, input logic [7:0] typ,
                                       input logic [15:0] klen, input logic [15:0] vlen);
    return '{lrf_pkg::CMD_OPEN, txn, typ, klen, vlen, 8'd0, 64'd0};
  endfunction

  function automatic cmd_word_t data_w(input logic [7:0] b);
    return '{lrf_pkg::CMD_DATA, 32'd0, 8'd0, 16'd0, 16'd0, b, 64'd0};
  endfunction

  function automatic cmd_word_t note_w(input logic [63:0] lsn);
    return '{lrf_pkg::CMD_NOTICE, 32'd0, 8'd0, 16'd0, 16'd0, 8'd0, lsn};
  endfunction

  function automatic dir_row_t plain(input cmd_word_t w);
    return '{w, 1'b0, lrf_pkg::ST_OK, 64'd0, 64'd0};
  endfunction

  function automatic dir_row_t typed_row(input cmd_word_t w, input logic [1:0] st,
                                         input logic [63:0] rec, input logic [63:0] fl);
    return '{w, 1'b1, st, rec, fl};
  endfunction

  task automatic send_word(input cmd_word_t w, input logic typed, input rec_word_t tw);
    int gap;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= w.cmd;
    in_ch.txn_id      <= w.txn;
    in_ch.rec_type    <= w.typ;
    in_ch.key_len     <= w.klen;
    in_ch.value_len   <= w.vlen;
    in_ch.data_byte   <= w.data;
    in_ch.written_lsn <= w.lsn;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    frame_command(w);
    if (typed) begin
      add_pending(tw);
    end else begin
      foreach (step_words[i]) add_pending(step_words[i]);
    end
  endtask

  task automatic send(input cmd_word_t w);
    send_word(w, 1'b0, '0);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_codes(input logic [7:0] p, input logic [7:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= lrf_pkg::REG_PUT_TYPE;
    cfg_data  <= p;
    @(posedge clk);
    cfg_index <= lrf_pkg::REG_DELETE_TYPE;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we   <= 1'b0;
    put_code = p;
    del_code = d;
  endtask

  function automatic logic [63:0] pick_lsn(input logic wide_lsn);
    if (wide_lsn && $urandom_range(0, 9) == 0) return {$urandom, $urandom};
    return nxt_lsn - {32'd0, $urandom_range(0, 4)};
  endfunction

  function automatic logic [7:0] other_type();
    logic [7:0] t;
    t = 8'($urandom_range(0, 255));
    while (t == put_code || t == del_code) t = t + 8'd1;
    return t;
  endfunction

  task automatic random_phase(input int n_items, input logic wide_lsn);
    int sent;
    int n_pay;
    int pick;
    logic [7:0] typ;
    logic [15:0] kl;
    logic [15:0] vl;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 7) == 0) tx_idle = ~tx_idle;
      if ($urandom_range(0, 7) == 0) rx_idle = ~rx_idle;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        pick = $urandom_range(0, 99);
        typ = (pick < 50) ? put_code : (pick < 75) ? del_code :
              8'($urandom_range(0, 255));
        kl = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) :
                                               $urandom_range(0, 5));
        vl = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) :
                                               $urandom_range(0, 5));
        n_pay = (typ == put_code) ? kl + vl : (typ == del_code) ? kl : 0;
        send(open_w($urandom, typ, kl, vl));
        sent++;
        repeat (n_pay) begin
          pick = $urandom_range(0, 39);
          if (pick == 0) begin
            send(note_w(pick_lsn(wide_lsn)));
            sent++;
          end else if (pick == 1) begin
            send(open_w($urandom, 8'($urandom_range(0, 255)),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))));
            sent++;
          end
          send(data_w(8'($urandom_range(0, 255))));
          sent++;
        end
      end else if (pick < 86) begin
        send(data_w(8'($urandom_range(0, 255))));
        sent++;
      end else if (pick < 93) begin
        send(note_w(pick_lsn(wide_lsn)));
        sent++;
      end else if (pick < 97) begin
        send(open_w($urandom, other_type(), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535))));
        sent++;
      end else begin
        send('{CMD_UNUSED, $urandom, 8'd0, 16'd0, 16'd0, 8'd0, 64'd0});
        sent++;
      end
    end
  endtask

  initial begin : rx_side
    int stall;
    rec_word_t got;
    rec_word_t want;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_byte, out_ch.byte_valid, out_ch.last, out_ch.crc,
                out_ch.record_lsn, out_ch.flushed_lsn, out_ch.status};
        if (pending_words.size() == 0) begin
          report("word with nothing expected, out_byte", 64'(got.out_byte), 64'd0);
        end else begin
          want = pending_words.pop_front();
          if (got.out_byte !== want.out_byte)
            report("out_byte", 64'(got.out_byte), 64'(want.out_byte));
          if (got.byte_valid !== want.byte_valid)
            report("byte_valid", 64'(got.byte_valid), 64'(want.byte_valid));
          if (got.last !== want.last)
            report("last", 64'(got.last), 64'(want.last));
          if (got.crc !== want.crc) report("crc", 64'(got.crc), 64'(want.crc));
          if (got.record_lsn !== want.record_lsn)
            report("record_lsn", got.record_lsn, want.record_lsn);
          if (got.flushed_lsn !== want.flushed_lsn)
            report("flushed_lsn", got.flushed_lsn, want.flushed_lsn);
          if (got.status !== want.status)
            report("status", 64'(got.status), 64'(want.status));
        end
        stall = rx_idle ? $urandom_range(0, 16) : 0;
      end else if (stall > 0) begin
        stall--;
      end
      out_ch.ready <= !rst && (stall == 0);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= lrf_pkg::CMD_OPEN;
    in_ch.txn_id      <= '0;
    in_ch.rec_type    <= '0;
    in_ch.key_len     <= '0;
    in_ch.value_len   <= '0;
    in_ch.data_byte   <= '0;
    in_ch.written_lsn <= '0;
    err_count = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    put_code = lrf_pkg::PUT_TYPE_RESET;
    del_code = lrf_pkg::DELETE_TYPE_RESET;
    nxt_lsn = 64'd1;
    flush_lsn = 64'd0;
    cur_lsn = 64'd0;
    crc_run = lrf_pkg::CRC_INIT;
    ph = PH_IDLE;
    left_cnt = 16'd0;
    vlen_hold = 16'd0;
    put_rec = 1'b0;

    add_row(typed_row(data_w(8'hA5), lrf_pkg::ST_NO_RECORD, 64'd0, 64'd0));
    add_row(typed_row(note_w(64'd0), lrf_pkg::ST_OK, 64'd0, 64'd0));
    add_row(typed_row(note_w(64'h10), lrf_pkg::ST_OK, 64'd0, 64'h10));
    add_row(typed_row(note_w(64'd5), lrf_pkg::ST_OK, 64'd0, 64'h10));
    add_row(plain(open_w(32'h0, 8'h00, 16'hFFFF, 16'hFFFF)));
    add_row(plain(open_w(32'hFFFF_FFFF, 8'hFF, 16'h0, 16'h0)));
    add_row(plain(open_w(32'hA5A5_A5A5, lrf_pkg::PUT_TYPE_RESET, 16'h0, 16'h0)));
    add_row(plain(open_w(32'h5A5A_5A5A, lrf_pkg::DELETE_TYPE_RESET, 16'h0, 16'hFFFF)));
    add_row(plain(open_w(32'h1234_5678, lrf_pkg::PUT_TYPE_RESET, 16'd2, 16'd1)));
    add_row(typed_row(open_w(32'hFFFF_FFFF, lrf_pkg::PUT_TYPE_RESET, 16'hFFFF, 16'hFFFF),
                      lrf_pkg::ST_BUSY, 64'd5, 64'h10));
    add_row(plain(data_w(8'h00)));
    add_row(plain(data_w(8'hFF)));
    add_row(plain(data_w(8'h5A)));
    add_row(typed_row(data_w(8'h3C), lrf_pkg::ST_NO_RECORD, 64'd5, 64'h10));
    add_row(plain(open_w(32'h0BAD_F00D, lrf_pkg::DELETE_TYPE_RESET, 16'd1, 16'd9)));
    add_row(plain(data_w(8'hC3)));
    add_row(plain(open_w(32'h0000_0001, lrf_pkg::PUT_TYPE_RESET, 16'd1, 16'd0)));
    add_row(plain(data_w(8'h81)));
    add_row(plain('{CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                    8'hFF, 64'hFFFF_FFFF_FFFF_FFFF}));
    add_row(plain(open_w(32'h8000_0001, lrf_pkg::PUT_TYPE_RESET, 16'd0, 16'd2)));
    add_row(plain(data_w(8'h7E)));
    add_row(typed_row(note_w(64'd8), lrf_pkg::ST_OK, 64'd8, 64'h10));
    add_row(plain(data_w(8'hE7)));
    add_row(typed_row(note_w(64'h20), lrf_pkg::ST_OK, 64'd8, 64'h20));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].w, dir_rows[i].typed,
                '{8'd0, 1'b0, 1'b0, 32'd0, dir_rows[i].record_lsn,
                  dir_rows[i].flushed_lsn, dir_rows[i].status});
    end

    random_phase(40, 1'b0);
    drain();
    random_phase(40, 1'b0);
    drain();
    write_codes(8'hFF, 8'h00);
    random_phase(70, 1'b0);
    drain();
    write_codes(8'h07, 8'h07);
    random_phase(70, 1'b0);
    drain();
    write_codes(8'h00, 8'hFF);
    random_phase(70, 1'b1);
    drain();
    write_codes(lrf_pkg::PUT_TYPE_RESET, lrf_pkg::DELETE_TYPE_RESET);

    send(note_w(64'hFFFF_FFFF_FFFF_FFFF));
    drain();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
